// ----- src/pnm_pixel_stream_decoder_assert.svh -----
// Assertion macros used by the pixel stream decoder datapath.
// Needs a clock and a synchronous active-high reset in scope.
`ifndef PNM_PIXEL_STREAM_DECODER_ASSERT_SVH
`define PNM_PIXEL_STREAM_DECODER_ASSERT_SVH

// same-cycle implication
`define PNM_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pnm assertion failed");

// next-cycle implication
`define PNM_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pnm assertion failed");

`endif

// ----- src/pnm_pkg.sv -----
// Shared types, codes and constants for the pixel stream decoder.
// No dependencies.
`default_nettype none

package pnm_pkg;

  localparam int DIM_BITS = 16;
  localparam int MAXV_W   = 16;
  localparam int ACC_W    = 17;
  localparam int Q_W      = 9;
  localparam int DVD_W    = MAXV_W + Q_W;
  localparam int PROD_W   = 2 * DIM_BITS;
  localparam int LEFT_W   = PROD_W + 1;
  localparam int OUT_W    = 72;
  localparam int ADDR_W   = 5;

  localparam logic [ACC_W-1:0] ACC_SAT = ACC_W'(65536);

  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [1:0] FMT_BITMAP = 2'd0;
  localparam logic [1:0] FMT_GREY   = 2'd1;
  localparam logic [1:0] FMT_PIXMAP = 2'd2;

  localparam logic [1:0] ENC_ASCII = 2'd0;
  localparam logic [1:0] ENC_RAW   = 2'd1;
  localparam logic [1:0] ENC_RLE   = 2'd2;

  localparam logic [1:0] KIND_RUN   = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [1:0] DS_IDLE = 2'd0;
  localparam logic [1:0] DS_RUN  = 2'd1;
  localparam logic [1:0] DS_DONE = 2'd2;
  localparam logic [1:0] DS_FAIL = 2'd3;

  localparam logic [1:0] PH_SKIP = 2'd0;
  localparam logic [1:0] PH_NUM  = 2'd1;
  localparam logic [1:0] PH_NOTE = 2'd2;

  localparam logic [2:0] REG_FORMAT   = 3'd0;
  localparam logic [2:0] REG_ENCODING = 3'd1;
  localparam logic [2:0] REG_WIDTH    = 3'd2;
  localparam logic [2:0] REG_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_MAXVAL   = 3'd4;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] WHITE    = 8'hff;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ASC_START, S_SAMPLE, S_SCALE, S_STORE, S_RUN_MUL,
    S_RUN_CHK, S_PUT, S_POS, S_POS_DIV, S_AFTER, S_PACK_PIX, S_FAIL, S_EMPTY,
    S_FINISH
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_START, OP_RELEASE, OP_FAIL_PUT, OP_EMPTY_PUT,
    OP_NOTE_CHK, OP_DIGIT, OP_NUM_END, OP_NUM_BEGIN, OP_NOTE_BEGIN, OP_SV_BYTE,
    OP_SET_BW, OP_DIV_SCALE, OP_STORE, OP_RL_RUN, OP_MUL, OP_CHK, OP_PUT_RUN,
    OP_POS_STEP, OP_DIV_POS, OP_POS_SET, OP_PACK_INIT, OP_PACK_BIT,
    OP_PACK_NEXT, OP_FINISH
  } op_t;

  typedef struct packed {
    logic [1:0]          fmt;
    logic [1:0]          enc;
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
    logic [MAXV_W-1:0]   maxv;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] fmt;
    logic [1:0] enc;
    logic [1:0] phase;
    logic       is_run;
    logic       cfg_ok;
    logic       empty;
    logic       ready;
    logic       c_space;
    logic       c_digit;
    logic       c_hash;
    logic       rl_full;
    logic       comp_last;
    logic       sample_bad;
    logic       div_done;
    logic       put_ok;
    logic       run_one;
    logic       fin;
    logic       pack_end;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- src/pnm_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Uses pnm_pkg; the partial remainder must start below the divisor.
`default_nettype none

module pnm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [pnm_pkg::DVD_W-1:0]  dividend,
  input  logic [pnm_pkg::MAXV_W-1:0] divisor,
  output logic                       busy,
  output logic [pnm_pkg::Q_W-1:0]    quotient,
  output logic [pnm_pkg::MAXV_W-1:0] remainder
);

  logic [pnm_pkg::MAXV_W-1:0] rem;
  logic [pnm_pkg::Q_W-1:0]    shq;
  logic [pnm_pkg::MAXV_W-1:0] dsr;
  logic [3:0]                 cnt;
  logic [pnm_pkg::MAXV_W:0]   trial;
  logic                       fits;

  assign trial = {rem, shq[pnm_pkg::Q_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= 4'(pnm_pkg::Q_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[pnm_pkg::DVD_W-1:pnm_pkg::Q_W];
      shq <= dividend[pnm_pkg::Q_W-1:0];
      dsr <= divisor;
    end else if (cnt != '0) begin
      rem <= fits ? pnm_pkg::MAXV_W'(trial - {1'b0, dsr}) : trial[pnm_pkg::MAXV_W-1:0];
      shq <= {shq[pnm_pkg::Q_W-2:0], fits};
    end
  end

  assign busy      = cnt != '0;
  assign quotient  = shq;
  assign remainder = rem;

endmodule

`default_nettype wire

// ----- src/pnm_ctrl.sv -----
// Sequencer for the pixel stream decoder: steps one transaction through
// lexing, sample check, rescale, run emission and position update. Uses pnm_pkg.
`default_nettype none

module pnm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  pnm_pkg::dp_stat_t stat,
  output pnm_pkg::op_t      op
);

  pnm_pkg::state_t state, state_next;
  logic            asc_num;

  assign asc_num = stat.enc == pnm_pkg::ENC_ASCII && stat.phase == pnm_pkg::PH_NUM;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pnm_pkg::S_IDLE: begin
        if (s_tvalid) state_next = pnm_pkg::S_DISPATCH;
      end
      pnm_pkg::S_DISPATCH: begin
        state_next = pnm_pkg::S_FINISH;
        if (stat.cmd == pnm_pkg::CMD_START) begin
          if (!stat.cfg_ok) state_next = pnm_pkg::S_FAIL;
          else if (stat.empty) state_next = pnm_pkg::S_EMPTY;
        end else if (stat.cmd == pnm_pkg::CMD_DATA && stat.is_run) begin
          if (!stat.ready) state_next = pnm_pkg::S_FAIL;
          else if (stat.enc == pnm_pkg::ENC_ASCII) begin
            if (stat.phase == pnm_pkg::PH_NUM)
              state_next = stat.c_digit ? pnm_pkg::S_FINISH : pnm_pkg::S_SAMPLE;
            else if (stat.phase != pnm_pkg::PH_NOTE)
              state_next = pnm_pkg::S_ASC_START;
          end else if (stat.enc == pnm_pkg::ENC_RLE) begin
            state_next = stat.rl_full ? pnm_pkg::S_RUN_MUL : pnm_pkg::S_SAMPLE;
          end else if (stat.fmt == pnm_pkg::FMT_BITMAP) begin
            state_next = pnm_pkg::S_PACK_PIX;
          end else begin
            state_next = pnm_pkg::S_SAMPLE;
          end
        end else if (stat.cmd == pnm_pkg::CMD_END && stat.is_run) begin
          if (!stat.ready) state_next = pnm_pkg::S_FAIL;
          else if (asc_num) state_next = pnm_pkg::S_SAMPLE;
          else state_next = pnm_pkg::S_FAIL;
        end
      end
      pnm_pkg::S_ASC_START: begin
        if (stat.c_space || stat.c_digit || stat.c_hash) state_next = pnm_pkg::S_FINISH;
        else state_next = pnm_pkg::S_FAIL;
      end
      pnm_pkg::S_SAMPLE: begin
        if (stat.sample_bad) state_next = pnm_pkg::S_FAIL;
        else if (stat.fmt == pnm_pkg::FMT_BITMAP) state_next = pnm_pkg::S_RUN_MUL;
        else state_next = pnm_pkg::S_SCALE;
      end
      pnm_pkg::S_SCALE: begin
        if (stat.div_done) state_next = pnm_pkg::S_STORE;
      end
      pnm_pkg::S_STORE: begin
        if (stat.enc == pnm_pkg::ENC_RLE) state_next = pnm_pkg::S_FINISH;
        else if (stat.fmt == pnm_pkg::FMT_GREY || stat.comp_last)
          state_next = pnm_pkg::S_RUN_MUL;
        else state_next = pnm_pkg::S_AFTER;
      end
      pnm_pkg::S_RUN_MUL: state_next = pnm_pkg::S_RUN_CHK;
      pnm_pkg::S_RUN_CHK: state_next = pnm_pkg::S_PUT;
      pnm_pkg::S_PUT: begin
        if (stat.put_ok) state_next = pnm_pkg::S_POS;
      end
      pnm_pkg::S_POS: begin
        state_next = (stat.fin || stat.run_one) ? pnm_pkg::S_AFTER : pnm_pkg::S_POS_DIV;
      end
      pnm_pkg::S_POS_DIV: begin
        if (stat.div_done) state_next = pnm_pkg::S_AFTER;
      end
      pnm_pkg::S_AFTER: begin
        state_next = pnm_pkg::S_FINISH;
        if (stat.cmd == pnm_pkg::CMD_END) begin
          if (stat.is_run) state_next = pnm_pkg::S_FAIL;
        end else if (stat.cmd == pnm_pkg::CMD_DATA) begin
          if (stat.enc == pnm_pkg::ENC_ASCII) begin
            if (stat.is_run && !stat.c_space) state_next = pnm_pkg::S_ASC_START;
          end else if (stat.enc == pnm_pkg::ENC_RAW && stat.fmt == pnm_pkg::FMT_BITMAP) begin
            if (stat.is_run && !stat.pack_end) state_next = pnm_pkg::S_PACK_PIX;
          end
        end
      end
      pnm_pkg::S_PACK_PIX: state_next = pnm_pkg::S_RUN_MUL;
      pnm_pkg::S_FAIL: begin
        if (stat.put_ok) state_next = pnm_pkg::S_FINISH;
      end
      pnm_pkg::S_EMPTY: begin
        if (stat.put_ok) state_next = pnm_pkg::S_FINISH;
      end
      pnm_pkg::S_FINISH: state_next = pnm_pkg::S_IDLE;
      default: state_next = pnm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op       = pnm_pkg::OP_NONE;
    s_tready = 1'b0;
    unique case (state)
      pnm_pkg::S_IDLE: begin
        s_tready = 1'b1;
        op       = pnm_pkg::OP_LATCH;
      end
      pnm_pkg::S_DISPATCH: begin
        if (stat.cmd == pnm_pkg::CMD_START) begin
          op = pnm_pkg::OP_START;
        end else if (stat.cmd == pnm_pkg::CMD_DATA && stat.is_run && stat.ready) begin
          if (stat.enc == pnm_pkg::ENC_ASCII) begin
            if (stat.phase == pnm_pkg::PH_NOTE) op = pnm_pkg::OP_NOTE_CHK;
            else if (stat.phase == pnm_pkg::PH_NUM)
              op = stat.c_digit ? pnm_pkg::OP_DIGIT : pnm_pkg::OP_NUM_END;
          end else if (stat.enc == pnm_pkg::ENC_RLE) begin
            op = stat.rl_full ? pnm_pkg::OP_RL_RUN : pnm_pkg::OP_SV_BYTE;
          end else if (stat.fmt == pnm_pkg::FMT_BITMAP) begin
            op = pnm_pkg::OP_PACK_INIT;
          end else begin
            op = pnm_pkg::OP_SV_BYTE;
          end
        end else if (stat.cmd == pnm_pkg::CMD_END && stat.is_run && stat.ready && asc_num) begin
          op = pnm_pkg::OP_NUM_END;
        end
      end
      pnm_pkg::S_ASC_START: begin
        if (stat.c_digit) op = pnm_pkg::OP_NUM_BEGIN;
        else if (stat.c_hash) op = pnm_pkg::OP_NOTE_BEGIN;
      end
      pnm_pkg::S_SAMPLE: begin
        if (!stat.sample_bad)
          op = (stat.fmt == pnm_pkg::FMT_BITMAP) ? pnm_pkg::OP_SET_BW : pnm_pkg::OP_DIV_SCALE;
      end
      pnm_pkg::S_SCALE:   op = pnm_pkg::OP_NONE;
      pnm_pkg::S_STORE:   op = pnm_pkg::OP_STORE;
      pnm_pkg::S_RUN_MUL: op = pnm_pkg::OP_MUL;
      pnm_pkg::S_RUN_CHK: op = pnm_pkg::OP_CHK;
      pnm_pkg::S_PUT:     op = stat.put_ok ? pnm_pkg::OP_PUT_RUN : pnm_pkg::OP_RELEASE;
      pnm_pkg::S_POS: begin
        op = (stat.fin || stat.run_one) ? pnm_pkg::OP_POS_STEP : pnm_pkg::OP_DIV_POS;
      end
      pnm_pkg::S_POS_DIV: begin
        if (stat.div_done) op = pnm_pkg::OP_POS_SET;
      end
      pnm_pkg::S_AFTER: begin
        if (stat.cmd == pnm_pkg::CMD_DATA && stat.enc == pnm_pkg::ENC_RAW &&
            stat.fmt == pnm_pkg::FMT_BITMAP && stat.is_run && !stat.pack_end)
          op = pnm_pkg::OP_PACK_NEXT;
      end
      pnm_pkg::S_PACK_PIX: op = pnm_pkg::OP_PACK_BIT;
      pnm_pkg::S_FAIL:     op = stat.put_ok ? pnm_pkg::OP_FAIL_PUT : pnm_pkg::OP_RELEASE;
      pnm_pkg::S_EMPTY:    op = stat.put_ok ? pnm_pkg::OP_EMPTY_PUT : pnm_pkg::OP_RELEASE;
      pnm_pkg::S_FINISH:   op = pnm_pkg::OP_FINISH;
      default:             op = pnm_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/pnm_dp.sv -----
// Datapath of the pixel stream decoder: decode state, lexer, run position,
// multiplier, shared divider and the output buffer. Uses pnm_pkg, pnm_div.
`default_nettype none
`include "pnm_pixel_stream_decoder_assert.svh"

module pnm_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  pnm_pkg::cfg_t             cfg,
  input  pnm_pkg::op_t              op,
  output pnm_pkg::dp_stat_t         stat,
  input  logic                      s_tvalid,
  input  logic [7:0]                s_tdata,
  input  logic [1:0]                s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [pnm_pkg::OUT_W-1:0] m_tdata,
  output logic [1:0]                m_tuser,
  output logic                      m_tlast
);

  localparam int DB = pnm_pkg::DIM_BITS;

  logic [1:0]              cmd;
  logic [7:0]              byte_in;
  logic [DB-1:0]           col, row;
  logic [pnm_pkg::ACC_W-1:0] acc, sv;
  logic [1:0]              phase, comp, status;
  logic [7:0]              red, green, blue, run_n;
  logic                    fin;
  logic [2:0]              bit_idx, pk_last;
  logic [pnm_pkg::PROD_W-1:0] prod;

  logic                    ob_full, ob_show, ob_last, ob_fin;
  logic [1:0]              ob_kind;
  logic [7:0]              ob_r, ob_g, ob_b, ob_rep;
  logic [DB-1:0]           ob_col, ob_row;

  logic                    div_start, div_busy;
  logic [pnm_pkg::DVD_W-1:0]  div_dvd;
  logic [pnm_pkg::MAXV_W-1:0] div_dsr;
  logic [pnm_pkg::Q_W-1:0]    div_q;
  logic [pnm_pkg::MAXV_W-1:0] div_r;

  logic                    cfg_ok;
  logic [pnm_pkg::ACC_W-1:0] limit;
  logic [19:0]             acc_mul;
  logic [pnm_pkg::LEFT_W-1:0] left;
  logic [DB-1:0]           w_left;
  logic [7:0]              qbyte;
  logic                    bw_bit;

  assign cfg_ok = cfg.fmt != 2'd3 && cfg.enc != 2'd3 &&
                  !(cfg.fmt == pnm_pkg::FMT_BITMAP && cfg.enc == pnm_pkg::ENC_RLE) &&
                  cfg.maxv != '0;
  assign limit   = (cfg.fmt == pnm_pkg::FMT_BITMAP) ? pnm_pkg::ACC_W'(1)
                                                    : pnm_pkg::ACC_W'(cfg.maxv);
  assign acc_mul = 20'({acc, 3'b000}) + 20'({acc, 1'b0}) + 20'(byte_in - pnm_pkg::CH_ZERO);
  assign w_left  = cfg.width - col;
  assign left    = pnm_pkg::LEFT_W'(prod) + pnm_pkg::LEFT_W'(w_left);
  assign qbyte   = div_q[7:0];
  assign bw_bit  = byte_in[3'd7 - bit_idx];

  assign div_start = op == pnm_pkg::OP_DIV_SCALE || op == pnm_pkg::OP_DIV_POS;
  always_comb begin
    if (op == pnm_pkg::OP_DIV_POS) begin
      div_dvd = pnm_pkg::DVD_W'(col) + pnm_pkg::DVD_W'(run_n);
      div_dsr = pnm_pkg::MAXV_W'(cfg.width);
    end else begin
      div_dvd = pnm_pkg::DVD_W'({sv[pnm_pkg::MAXV_W-1:0], 8'h00})
              - pnm_pkg::DVD_W'(sv[pnm_pkg::MAXV_W-1:0]);
      div_dsr = cfg.maxv;
    end
  end

  pnm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    stat.cmd        = cmd;
    stat.fmt        = cfg.fmt;
    stat.enc        = cfg.enc;
    stat.phase      = phase;
    stat.is_run     = status == pnm_pkg::DS_RUN;
    stat.cfg_ok     = cfg_ok;
    stat.empty      = cfg.width == '0 || cfg.height == '0;
    stat.ready      = cfg_ok && col < cfg.width && row < cfg.height;
    stat.c_space    = byte_in == pnm_pkg::CH_SPACE ||
                      (byte_in >= pnm_pkg::CH_TAB && byte_in <= pnm_pkg::CH_CR);
    stat.c_digit    = byte_in >= pnm_pkg::CH_ZERO && byte_in <= pnm_pkg::CH_NINE;
    stat.c_hash     = byte_in == pnm_pkg::CH_HASH;
    stat.rl_full    = comp >= ((cfg.fmt == pnm_pkg::FMT_GREY) ? 2'd1 : 2'd3);
    stat.comp_last  = comp == 2'd2;
    stat.sample_bad = sv > limit;
    stat.div_done   = !div_busy;
    stat.put_ok     = !ob_full;
    stat.run_one    = run_n == 8'd1;
    stat.fin        = fin;
    stat.pack_end   = bit_idx == pk_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      acc     <= '0;
      phase   <= pnm_pkg::PH_SKIP;
      comp    <= '0;
      red     <= '0;
      green   <= '0;
      blue    <= '0;
      status  <= pnm_pkg::DS_IDLE;
      cmd     <= '0;
      byte_in <= '0;
      sv      <= '0;
      run_n   <= '0;
      fin     <= 1'b0;
      bit_idx <= '0;
      pk_last <= '0;
      prod    <= '0;
    end else begin
      case (op)
        pnm_pkg::OP_LATCH: begin
          if (s_tvalid) begin
            cmd     <= s_tuser;
            byte_in <= s_tdata;
          end
        end
        pnm_pkg::OP_START: begin
          col   <= '0;
          row   <= '0;
          acc   <= '0;
          phase <= pnm_pkg::PH_SKIP;
          comp  <= '0;
          red   <= '0;
          green <= '0;
          blue  <= '0;
          if (cfg_ok && cfg.width != '0 && cfg.height != '0) status <= pnm_pkg::DS_RUN;
        end
        pnm_pkg::OP_FAIL_PUT:  status <= pnm_pkg::DS_FAIL;
        pnm_pkg::OP_EMPTY_PUT: status <= pnm_pkg::DS_DONE;
        pnm_pkg::OP_NOTE_CHK: begin
          if (byte_in == pnm_pkg::CH_LF) phase <= pnm_pkg::PH_SKIP;
        end
        pnm_pkg::OP_DIGIT: begin
          acc <= (acc_mul > 20'(pnm_pkg::ACC_SAT)) ? pnm_pkg::ACC_SAT
                                                   : acc_mul[pnm_pkg::ACC_W-1:0];
        end
        pnm_pkg::OP_NUM_END: begin
          phase <= pnm_pkg::PH_SKIP;
          sv    <= acc;
        end
        pnm_pkg::OP_NUM_BEGIN: begin
          acc   <= pnm_pkg::ACC_W'(byte_in - pnm_pkg::CH_ZERO);
          phase <= pnm_pkg::PH_NUM;
        end
        pnm_pkg::OP_NOTE_BEGIN: phase <= pnm_pkg::PH_NOTE;
        pnm_pkg::OP_SV_BYTE:    sv <= pnm_pkg::ACC_W'(byte_in);
        pnm_pkg::OP_SET_BW: begin
          red   <= (sv != '0) ? 8'h00 : pnm_pkg::WHITE;
          green <= (sv != '0) ? 8'h00 : pnm_pkg::WHITE;
          blue  <= (sv != '0) ? 8'h00 : pnm_pkg::WHITE;
          run_n <= 8'd1;
        end
        pnm_pkg::OP_STORE: begin
          if (cfg.fmt == pnm_pkg::FMT_GREY) begin
            red   <= qbyte;
            green <= qbyte;
            blue  <= qbyte;
          end else begin
            case (comp)
              2'd0:    red   <= qbyte;
              2'd1:    green <= qbyte;
              default: blue  <= qbyte;
            endcase
          end
          if (cfg.enc == pnm_pkg::ENC_RLE || cfg.fmt == pnm_pkg::FMT_GREY) begin
            comp <= (cfg.enc == pnm_pkg::ENC_RLE) ? comp + 2'd1 : comp;
          end else begin
            comp <= (comp == 2'd2) ? 2'd0 : comp + 2'd1;
          end
          run_n <= 8'd1;
        end
        pnm_pkg::OP_RL_RUN: begin
          comp  <= '0;
          run_n <= (byte_in == '0) ? 8'd1 : byte_in;
        end
        pnm_pkg::OP_MUL: prod <= (cfg.height - DB'(1) - row) * cfg.width;
        pnm_pkg::OP_CHK: begin
          if (pnm_pkg::LEFT_W'(run_n) >= left) begin
            run_n <= left[7:0];
            fin   <= 1'b1;
          end else begin
            fin   <= 1'b0;
          end
        end
        pnm_pkg::OP_POS_STEP: begin
          if (fin) begin
            status <= pnm_pkg::DS_DONE;
          end else if (col + DB'(1) == cfg.width) begin
            col <= '0;
            row <= row + DB'(1);
          end else begin
            col <= col + DB'(1);
          end
        end
        pnm_pkg::OP_POS_SET: begin
          col <= div_r[DB-1:0];
          row <= row + DB'(div_q);
        end
        pnm_pkg::OP_PACK_INIT: begin
          bit_idx <= '0;
          pk_last <= (w_left > DB'(8)) ? 3'd7 : 3'(w_left[2:0] - 3'd1);
        end
        pnm_pkg::OP_PACK_BIT: begin
          red   <= bw_bit ? 8'h00 : pnm_pkg::WHITE;
          green <= bw_bit ? 8'h00 : pnm_pkg::WHITE;
          blue  <= bw_bit ? 8'h00 : pnm_pkg::WHITE;
          run_n <= 8'd1;
        end
        pnm_pkg::OP_PACK_NEXT: bit_idx <= bit_idx + 3'd1;
        default: ;
      endcase
    end
  end

  // output buffer: the newest result is held unshown until the next result
  // or the end of the transaction tells whether it is the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_full <= 1'b0;
      ob_show <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      ob_full <= 1'b0;
      ob_show <= 1'b0;
    end else if (op == pnm_pkg::OP_PUT_RUN || op == pnm_pkg::OP_FAIL_PUT ||
                 op == pnm_pkg::OP_EMPTY_PUT) begin
      ob_full <= 1'b1;
    end else if ((op == pnm_pkg::OP_RELEASE || op == pnm_pkg::OP_FINISH) && ob_full) begin
      ob_show <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (op == pnm_pkg::OP_PUT_RUN) begin
      ob_kind <= pnm_pkg::KIND_RUN;
      ob_r    <= red;
      ob_g    <= green;
      ob_b    <= blue;
      ob_rep  <= run_n;
      ob_col  <= col;
      ob_row  <= row;
      ob_fin  <= fin;
    end else if (op == pnm_pkg::OP_FAIL_PUT || op == pnm_pkg::OP_EMPTY_PUT) begin
      ob_kind <= (op == pnm_pkg::OP_FAIL_PUT) ? pnm_pkg::KIND_ERROR : pnm_pkg::KIND_EMPTY;
      ob_r    <= '0;
      ob_g    <= '0;
      ob_b    <= '0;
      ob_rep  <= '0;
      ob_col  <= '0;
      ob_row  <= '0;
      ob_fin  <= op == pnm_pkg::OP_EMPTY_PUT;
    end
    if (!ob_show && ob_full) begin
      if (op == pnm_pkg::OP_RELEASE) ob_last <= 1'b0;
      else if (op == pnm_pkg::OP_FINISH) ob_last <= 1'b1;
    end
  end

  assign m_tvalid = ob_show;
  assign m_tuser  = ob_kind;
  assign m_tlast  = ob_last;
  assign m_tdata  = {7'd0, ob_fin, 16'(ob_row), 16'(ob_col), ob_rep, ob_b, ob_g, ob_r};

  `PNM_ASSERT_IMPL(a_put_free, clk, rst,
    op == pnm_pkg::OP_PUT_RUN || op == pnm_pkg::OP_FAIL_PUT || op == pnm_pkg::OP_EMPTY_PUT,
    !ob_full)
  `PNM_ASSERT_IMPL(a_div_idle, clk, rst, div_start, !div_busy)
  `PNM_ASSERT_IMPL(a_show_full, clk, rst, ob_show, ob_full)
  `PNM_ASSERT_NEXT(a_fin_done, clk, rst, op == pnm_pkg::OP_POS_STEP && fin,
    status == pnm_pkg::DS_DONE)

endmodule

`default_nettype wire

// ----- src/pnm_pixel_stream_decoder.sv -----
// Top level of the netpbm pixel body decoder: register file on the APB-style
// port, sequencer and datapath. Uses pnm_pkg, pnm_ctrl, pnm_dp.
//
//   port group   dir   payload
//   s_t*         in    tuser: command[1:0]; tdata: data_byte[7:0]
//   m_t*         out   tuser: result_kind[1:0]; tlast: last_of_step;
//                      tdata: red, green, blue, repeat_count, pixel_column,
//                             pixel_row, image_complete (from bit 0 up)
//   p*           cfg   format@0, encoding@4, width@8, height@12, max_value@16
//
// A pixel run adds the row-offset multiply, clamp, load and position
// step; a rescale or a multi-pixel position update runs on the 9-step
// radix-2 divider. A packed bitmap byte is unpacked one pixel after another.
// rst is synchronous: configuration and decode registers take reset values, decoding goes idle.
// The last result of a transaction waits in the output register while the next
// transaction is taken; any further result stalls until m_tready.
`default_nettype none

module pnm_pixel_stream_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // data_byte
  input  logic [1:0]                 s_tuser,   // command
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [pnm_pkg::OUT_W-1:0]  m_tdata,   // red, green, blue, repeat_count,
                                                // pixel_column, pixel_row, image_complete
  output logic [1:0]                 m_tuser,   // result_kind
  output logic                       m_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pnm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  pnm_pkg::cfg_t     cfg;
  pnm_pkg::op_t      op;
  pnm_pkg::dp_stat_t stat;
  logic              wr_en;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fmt    <= pnm_pkg::FMT_PIXMAP;
      cfg.enc    <= pnm_pkg::ENC_RAW;
      cfg.width  <= '0;
      cfg.height <= '0;
      cfg.maxv   <= pnm_pkg::MAXV_W'(255);
    end else if (wr_en) begin
      unique case (reg_idx)
        pnm_pkg::REG_FORMAT:   cfg.fmt    <= pwdata[1:0];
        pnm_pkg::REG_ENCODING: cfg.enc    <= pwdata[1:0];
        pnm_pkg::REG_WIDTH:    cfg.width  <= pwdata[pnm_pkg::DIM_BITS-1:0];
        pnm_pkg::REG_HEIGHT:   cfg.height <= pwdata[pnm_pkg::DIM_BITS-1:0];
        pnm_pkg::REG_MAXVAL:   cfg.maxv   <= pwdata[pnm_pkg::MAXV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pnm_pkg::REG_FORMAT:   prdata = 32'(cfg.fmt);
      pnm_pkg::REG_ENCODING: prdata = 32'(cfg.enc);
      pnm_pkg::REG_WIDTH:    prdata = 32'(cfg.width);
      pnm_pkg::REG_HEIGHT:   prdata = 32'(cfg.height);
      pnm_pkg::REG_MAXVAL:   prdata = 32'(cfg.maxv);
      default:               prdata = '0;
    endcase
  end

  pnm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .op       (op)
  );

  pnm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op       (op),
    .stat     (stat),
    .s_tvalid (s_tvalid),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// ----- test/pnm_decoder_checker.sv -----
// Checker for the netpbm pixel body decoder: follows APB register writes,
// predicts the pixel runs of every accepted input transaction, compares results.
// Depends on pnm_pkg.
`timescale 1ns / 100ps

module pnm_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          pending
);

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  count;
    logic [15:0] col;
    logic [15:0] row;
    logic        fin;
    logic        last;
  } pix_result_t;

  pix_result_t expected_runs[$];

  logic [1:0]  fmt, enc;
  logic [15:0] width, height, maxv;
  int unsigned col_pos, row_pos, acc, phase, comp, hr, hg, hb, status;
  int          step_results;

  task automatic push_result(logic [1:0] kind, int unsigned rep, int unsigned c,
                             int unsigned r, logic fin);
    pix_result_t e;
    bit pix;
    pix = (kind == pnm_pkg::KIND_RUN);
    if (step_results >= 8) return;
    e.kind  = kind;
    e.red   = pix ? hr[7:0] : 8'd0;
    e.green = pix ? hg[7:0] : 8'd0;
    e.blue  = pix ? hb[7:0] : 8'd0;
    e.count = pix ? rep[7:0] : 8'd0;
    e.col   = pix ? c[15:0] : 16'd0;
    e.row   = pix ? r[15:0] : 16'd0;
    e.fin   = fin;
    e.last  = 1'b0;
    expected_runs.push_back(e);
    step_results++;
  endtask

  task automatic fail_image();
    push_result(pnm_pkg::KIND_ERROR, 0, 0, 0, 1'b0);
    status = pnm_pkg::DS_FAIL;
  endtask

  function automatic bit cfg_ok();
    if (fmt > pnm_pkg::FMT_PIXMAP || enc > pnm_pkg::ENC_RLE) return 0;
    if (fmt == pnm_pkg::FMT_BITMAP && enc == pnm_pkg::ENC_RLE) return 0;
    return maxv != 0;
  endfunction

  function automatic int unsigned scale_sample(int unsigned v);
    if (maxv == 255 || maxv == 0) return v & 8'hff;
    return (v * 255) / maxv;
  endfunction

  function automatic bit is_space(int unsigned c);
    return c == pnm_pkg::CH_SPACE || (c >= pnm_pkg::CH_TAB && c <= pnm_pkg::CH_CR);
  endfunction

  function automatic bit is_digit(int unsigned c);
    return c >= pnm_pkg::CH_ZERO && c <= pnm_pkg::CH_NINE;
  endfunction

  task automatic emit_run(int unsigned n_in);
    longint unsigned w, total, pos, n, left;
    w = width;
    total = w * height;
    pos = longint'(row_pos) * w + col_pos;
    n = n_in;
    left = total - pos;
    if (n > left) n = left;
    push_result(pnm_pkg::KIND_RUN, n, col_pos, row_pos, (pos + n == total));
    pos += n;
    col_pos = pos % w;
    row_pos = pos / w;
    if (pos == total) status = pnm_pkg::DS_DONE;
  endtask

  task automatic set_grey(int unsigned g);
    hr = g; hg = g; hb = g;
  endtask

  task automatic take_sample(int unsigned v);
    int unsigned lim, s;
    lim = (fmt == pnm_pkg::FMT_BITMAP) ? 1 : maxv;
    if (v > lim) begin
      fail_image();
      return;
    end
    if (fmt == pnm_pkg::FMT_BITMAP) begin
      set_grey(v ? 0 : 255);
      emit_run(1);
      return;
    end
    s = scale_sample(v);
    if (fmt == pnm_pkg::FMT_GREY) begin
      set_grey(s);
      emit_run(1);
      return;
    end
    if (comp == 0) begin
      hr = s; comp = 1;
    end else if (comp == 1) begin
      hg = s; comp = 2;
    end else begin
      hb = s; comp = 0; emit_run(1);
    end
  endtask

  task automatic ascii_in(int unsigned c);
    if (phase == pnm_pkg::PH_NOTE) begin
      if (c == pnm_pkg::CH_LF) phase = pnm_pkg::PH_SKIP;
      return;
    end
    if (phase == pnm_pkg::PH_NUM) begin
      if (is_digit(c)) begin
        acc = acc * 10 + (c - pnm_pkg::CH_ZERO);
        if (acc > pnm_pkg::ACC_SAT) acc = pnm_pkg::ACC_SAT;
        return;
      end
      phase = pnm_pkg::PH_SKIP;
      take_sample(acc);
      if (status != pnm_pkg::DS_RUN || is_space(c)) return;
    end
    if (is_space(c)) return;
    if (is_digit(c)) begin
      acc = c - pnm_pkg::CH_ZERO;
      phase = pnm_pkg::PH_NUM;
    end else if (c == pnm_pkg::CH_HASH) phase = pnm_pkg::PH_NOTE;
    else fail_image();
  endtask

  task automatic packed_in(int unsigned b);
    int unsigned n;
    n = width - col_pos;
    if (n > 8) n = 8;
    for (int unsigned i = 0; i < n && status == pnm_pkg::DS_RUN; i++) begin
      set_grey(((b >> (7 - i)) & 1) ? 0 : 255);
      emit_run(1);
    end
  endtask

  task automatic runlength_in(int unsigned b);
    int unsigned last;
    last = (fmt == pnm_pkg::FMT_GREY) ? 1 : 3;
    if (comp >= last) begin
      comp = 0;
      emit_run(b == 0 ? 1 : b);
      return;
    end
    if (b > maxv) begin
      fail_image();
      return;
    end
    if (fmt == pnm_pkg::FMT_GREY) set_grey(scale_sample(b));
    else if (comp == 0) hr = scale_sample(b);
    else if (comp == 1) hg = scale_sample(b);
    else hb = scale_sample(b);
    comp++;
  endtask

  task automatic clear_decode();
    col_pos = 0; row_pos = 0; acc = 0; phase = pnm_pkg::PH_SKIP; comp = 0;
    hr = 0; hg = 0; hb = 0;
  endtask

  task automatic decode_item(logic [1:0] cmd, logic [7:0] b);
    bit rdy;
    step_results = 0;
    rdy = cfg_ok() && col_pos < width && row_pos < height;
    if (cmd == pnm_pkg::CMD_START) begin
      clear_decode();
      if (!cfg_ok()) fail_image();
      else if (width == 0 || height == 0) begin
        push_result(pnm_pkg::KIND_EMPTY, 0, 0, 0, 1'b1);
        status = pnm_pkg::DS_DONE;
      end else status = pnm_pkg::DS_RUN;
    end else if (cmd == pnm_pkg::CMD_DATA && status == pnm_pkg::DS_RUN) begin
      if (!rdy) fail_image();
      else if (enc == pnm_pkg::ENC_ASCII) ascii_in(b);
      else if (enc == pnm_pkg::ENC_RLE) runlength_in(b);
      else if (fmt == pnm_pkg::FMT_BITMAP) packed_in(b);
      else take_sample(b);
    end else if (cmd == pnm_pkg::CMD_END && status == pnm_pkg::DS_RUN) begin
      if (!rdy) fail_image();
      else begin
        if (enc == pnm_pkg::ENC_ASCII && phase == pnm_pkg::PH_NUM) begin
          phase = pnm_pkg::PH_SKIP;
          take_sample(acc);
        end
        if (status == pnm_pkg::DS_RUN) fail_image();
      end
    end
    if (step_results > 0) expected_runs[$].last = 1'b1;
  endtask

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fmt = pnm_pkg::FMT_PIXMAP; enc = pnm_pkg::ENC_RAW; width = 0; height = 0; maxv = 255;
      clear_decode();
      status = pnm_pkg::DS_IDLE;
      expected_runs.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_runs.size() == 0) begin
          $error("unexpected result transaction, kind %0d", m_tuser);
          mismatches++;
        end else begin
          pix_result_t e;
          e = expected_runs.pop_front();
          check_field("result_kind", e.kind, m_tuser);
          check_field("red", e.red, m_tdata[7:0]);
          check_field("green", e.green, m_tdata[15:8]);
          check_field("blue", e.blue, m_tdata[23:16]);
          check_field("repeat_count", e.count, m_tdata[31:24]);
          check_field("pixel_column", e.col, m_tdata[47:32]);
          check_field("pixel_row", e.row, m_tdata[63:48]);
          check_field("image_complete", e.fin, m_tdata[64]);
          check_field("last_of_step", e.last, m_tlast);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          pnm_pkg::REG_FORMAT:   fmt = pwdata[1:0];
          pnm_pkg::REG_ENCODING: enc = pwdata[1:0];
          pnm_pkg::REG_WIDTH:    width = pwdata[15:0];
          pnm_pkg::REG_HEIGHT:   height = pwdata[15:0];
          pnm_pkg::REG_MAXVAL:   maxv = pwdata[15:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) decode_item(s_tuser, s_tdata);
    end
    pending = expected_runs.size();
  end

endmodule

// ----- test/tb.sv -----
// Testbench top for the netpbm pixel body decoder: drives images in every
// format and encoding plus broken bodies; pnm_decoder_checker does the checking.
`timescale 1ns / 100ps

module tb;

  localparam int ITEM_TARGET = 305;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;
  logic [1:0]  s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches, pending;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          hold_go = 0;

  always #4 clk = ~clk;

  pnm_pixel_stream_decoder DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pnm_decoder_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .pending
  );

  // receiver: stall pattern redrawn at random from three modes, one long hold-off
  initial begin
    int mode;
    bit held;
    held = 0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat (64) begin
        @(negedge clk);
        if (hold_go && !held) begin
          held = 1;
          m_tready = 0;
          repeat (400) @(negedge clk);
        end
        case (mode)
          0: m_tready = 1;
          1: m_tready = ($urandom_range(0, 3) != 0);
          default: m_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #4ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send(logic [1:0] cmd, logic [7:0] b);
    if (burst_left == 0) begin
      @(negedge clk);
      s_tvalid = 0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end else @(negedge clk);
    s_tvalid = 1;
    s_tuser = cmd;
    s_tdata = b;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    items_sent++;
  endtask

  task automatic data(logic [7:0] b);
    send(pnm_pkg::CMD_DATA, b);
  endtask

  task automatic settle();
    @(negedge clk);
    s_tvalid = 0;
    burst_left = 0;
    wait (pending == 0);
    repeat (64) @(negedge clk);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic set_image(int f, int e, int w, int h, int mv);
    settle();
    apb_write(pnm_pkg::REG_FORMAT, f);
    apb_write(pnm_pkg::REG_ENCODING, e);
    apb_write(pnm_pkg::REG_WIDTH, w);
    apb_write(pnm_pkg::REG_HEIGHT, h);
    apb_write(pnm_pkg::REG_MAXVAL, mv);
    send(pnm_pkg::CMD_START, $urandom_range(0, 255));
  endtask

  task automatic ascii_number(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) data(s[i]);
  endtask

  task automatic ascii_gap();
    case ($urandom_range(0, 5))
      0: data(pnm_pkg::CH_TAB);
      1: data(pnm_pkg::CH_LF);
      2: data(pnm_pkg::CH_CR);
      3: begin
        data(pnm_pkg::CH_HASH);
        data($urandom_range(33, 126));
        data(pnm_pkg::CH_LF);
      end
      default: data(pnm_pkg::CH_SPACE);
    endcase
  endtask

  function automatic int unsigned pick_sample(int lim, int cap);
    if ($urandom_range(0, 14) == 0) return lim + 1;
    return $urandom_range(0, (lim < cap) ? lim : cap);
  endfunction

  task automatic random_image();
    int f, e, w, h, mv, comps, lim, n;
    f = $urandom_range(0, 2);
    e = $urandom_range(0, 2);
    if (f == pnm_pkg::FMT_BITMAP && e == pnm_pkg::ENC_RLE && $urandom_range(0, 4) != 0)
      e = pnm_pkg::ENC_RAW;
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 4);
    if ($urandom_range(0, 20) == 0) h = 0;
    case ($urandom_range(0, 5))
      0: mv = 1;
      1: mv = 255;
      2: mv = 65535;
      3: mv = $urandom_range(256, 65535);
      default: mv = $urandom_range(1, 255);
    endcase
    if ($urandom_range(0, 30) == 0) mv = 0;
    set_image(f, e, w, h, mv);
    comps = (f == pnm_pkg::FMT_PIXMAP) ? 3 : 1;
    lim = (f == pnm_pkg::FMT_BITMAP) ? 1 : mv;
    if (e == pnm_pkg::ENC_RAW && f == pnm_pkg::FMT_BITMAP) n = h * ((w + 7) / 8);
    else if (e == pnm_pkg::ENC_RLE) n = $urandom_range(1, 4);
    else n = w * h * comps;
    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
    for (int i = 0; i < n; i++) begin
      if (items_sent >= ITEM_TARGET) break;
      if ($urandom_range(0, 15) == 0) data($urandom_range(0, 255));
      if (e == pnm_pkg::ENC_ASCII) begin
        ascii_number(pick_sample(lim, 70000));
        ascii_gap();
      end else if (e == pnm_pkg::ENC_RLE) begin
        for (int c = 0; c < comps; c++) data(pick_sample(lim, 255));
        data($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 6));
      end else if (f == pnm_pkg::FMT_BITMAP) data($urandom_range(0, 255));
      else data(pick_sample(lim, 255));
    end
    if ($urandom_range(0, 2) == 0) send(pnm_pkg::CMD_END, $urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) send(2'd3, $urandom_range(0, 255));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // idle: data, end and the unused command produce nothing
    data(8'hff);
    send(pnm_pkg::CMD_END, 8'h00);
    send(2'd3, 8'h5a);
    // bad configurations
    set_image(3, pnm_pkg::ENC_RAW, 4, 4, 255);
    data(8'h00);
    set_image(pnm_pkg::FMT_GREY, 3, 4, 4, 255);
    set_image(pnm_pkg::FMT_BITMAP, pnm_pkg::ENC_RLE, 4, 4, 255);
    set_image(pnm_pkg::FMT_GREY, pnm_pkg::ENC_RAW, 4, 4, 0);
    // empty images
    set_image(pnm_pkg::FMT_GREY, pnm_pkg::ENC_RAW, 0, 5, 255);
    set_image(pnm_pkg::FMT_PIXMAP, pnm_pkg::ENC_RAW, 65535, 0, 255);
    // largest image, early end
    set_image(pnm_pkg::FMT_GREY, pnm_pkg::ENC_RAW, 65535, 65535, 65535);
    data(8'h00);
    data(8'hff);
    send(pnm_pkg::CMD_END, 8'h00);
    // ascii: comment, largest sample, saturating number
    set_image(pnm_pkg::FMT_GREY, pnm_pkg::ENC_ASCII, 2, 1, 65535);
    data(pnm_pkg::CH_HASH); data(8'h41); data(pnm_pkg::CH_LF);
    ascii_number(65535); data(pnm_pkg::CH_TAB);
    ascii_number(99999);
    send(pnm_pkg::CMD_END, 8'h00);
    // bitmap ascii with an out-of-range sample ended by a bad byte
    set_image(pnm_pkg::FMT_BITMAP, pnm_pkg::ENC_ASCII, 3, 1, 1);
    data("1"); data("0"); data("x");
    // pixmap run-length, zero count and a run cut at image end
    set_image(pnm_pkg::FMT_PIXMAP, pnm_pkg::ENC_RLE, 4, 2, 255);
    data(10); data(20); data(30); data(0);
    data(255); data(0); data(128); data(200);
    // packed bits with spare bits at the row end
    set_image(pnm_pkg::FMT_BITMAP, pnm_pkg::ENC_RAW, 10, 2, 1);
    data(8'ha5); data(8'hc0); data(8'hff); data(8'h01);

    hold_go = 1;
    while (items_sent < ITEM_TARGET) random_image();

    @(negedge clk);
    s_tvalid = 0;
    wait (pending == 0);
    repeat (100) @(negedge clk);
    if (mismatches == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
